// ===== hdl/mbrf_pkg.sv =====
// Package of the Modbus RTU request framer: byte slot kinds, function codes
// and the CRC-16/MODBUS byte update. Depends on nothing else.
package mbrf_pkg;

  typedef enum logic [1:0] {
    KIND_DATA   = 2'd0,
    KIND_CRC_LO = 2'd1,
    KIND_CRC_HI = 2'd2,
    KIND_BAD    = 2'd3
  } kind_e;

  localparam logic [7:0]  FC_READ_COILS      = 8'h01;
  localparam logic [7:0]  FC_WRITE_SINGLE_REG = 8'h06;
  localparam logic [7:0]  FC_WRITE_COIL      = 8'h05;
  localparam logic [7:0]  FC_WRITE_COILS     = 8'h0F;
  localparam logic [7:0]  FC_WRITE_REGS      = 8'h10;
  localparam logic [15:0] COIL_ON_WORD       = 16'hFF00;
  localparam logic [15:0] CRC_INIT           = 16'hFFFF;
  localparam logic [15:0] CRC_POLY           = 16'hA001;
  localparam int unsigned SLOTS              = 8;

  // Fold one byte into the reflected CRC, one bit per step.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

// ===== hdl/modbus_rtu_request_framer.sv =====
// Modbus RTU master request framer: turns header and payload items into the
// request byte stream with CRC-16/MODBUS. Depends on mbrf_pkg.
//
// An item's bytes pass the job register, then the output register, to frame_byte_o.
// Throughput: one byte per cycle while out_stall_i is low; the input is stalled until
// the current item's last byte moves on. An item emits 8 bytes for codes 1 to 6, 7 for
// a 15/16 header, 1 for a rejected header and 0 to 4 for a payload item.
// Reset (rst_ni low, asynchronous) closes any open frame and empties the pipeline.
module modbus_rtu_request_framer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  device_id_i,
  input  logic [7:0]  function_code_i,
  input  logic [15:0] start_address_i,
  input  logic [10:0] quantity_i,
  input  logic [15:0] value_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  frame_byte_o,
  output logic        frame_end_o,
  output logic        bad_request_o
);

  // Frame state. It is updated at the transfer of each item, so the decode
  // of the next item already sees it while earlier bytes are still leaving.
  logic        frame_open_q, frame_open_d;
  logic        open_coil_q, open_coil_d;
  logic [10:0] elements_left_q, elements_left_d;
  logic [7:0]  coil_pack_q, coil_pack_d;
  logic [2:0]  coil_bit_pos_q, coil_bit_pos_d;

  // Job register: the bytes one item emits, each with its kind.
  logic                job_valid_q;
  logic                job_init_q, job_init_d;
  logic [2:0]          job_idx_q;
  logic [2:0]          job_last_q, job_last_d;
  logic [7:0]          job_byte_q [mbrf_pkg::SLOTS];
  logic [7:0]          job_byte_d [mbrf_pkg::SLOTS];
  mbrf_pkg::kind_e     job_kind_q [mbrf_pkg::SLOTS];
  mbrf_pkg::kind_e     job_kind_d [mbrf_pkg::SLOTS];
  logic                job_make;

  // Running CRC, folded as the data bytes move into the output register.
  logic [15:0] crc_q, crc_d;

  // Output register.
  logic        out_valid_q;
  logic [7:0]  out_byte_q, out_byte_d;
  logic        out_end_q, out_end_d;
  logic        out_bad_q, out_bad_d;

  logic        advance;
  logic        job_done;
  logic        in_xfer;

  assign advance    = !out_valid_q || !out_stall_i;
  assign job_done   = job_valid_q && advance && (job_idx_q == job_last_q);
  assign in_stall_o = job_valid_q && !job_done;
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Item decode: next frame state and the job that the item produces.
  always_comb begin
    logic [15:0] word;
    logic [11:0] qty_round;
    logic [7:0]  count;
    logic [7:0]  pack_new;
    logic        fc_short;
    logic        fc_long;
    frame_open_d    = frame_open_q;
    open_coil_d     = open_coil_q;
    elements_left_d = elements_left_q;
    coil_pack_d     = coil_pack_q;
    coil_bit_pos_d  = coil_bit_pos_q;
    job_make        = 1'b0;
    job_init_d      = 1'b0;
    job_last_d      = 3'd0;
    for (int s = 0; s < mbrf_pkg::SLOTS; s++) begin
      job_byte_d[s] = 8'h00;
      job_kind_d[s] = mbrf_pkg::KIND_DATA;
    end
    fc_short  = (function_code_i >= mbrf_pkg::FC_READ_COILS) &&
                (function_code_i <= mbrf_pkg::FC_WRITE_SINGLE_REG);
    fc_long   = (function_code_i == mbrf_pkg::FC_WRITE_COILS) ||
                (function_code_i == mbrf_pkg::FC_WRITE_REGS);
    qty_round = {1'b0, quantity_i} + 12'd7;
    if (function_code_i == mbrf_pkg::FC_WRITE_COILS) begin
      count = qty_round[10:3];
    end else begin
      count = {quantity_i[6:0], 1'b0};
    end
    if (function_code_i == mbrf_pkg::FC_WRITE_COIL) begin
      word = (value_i == 16'd1) ? mbrf_pkg::COIL_ON_WORD : 16'h0000;
    end else if (function_code_i == mbrf_pkg::FC_WRITE_SINGLE_REG) begin
      word = value_i;
    end else begin
      word = {5'd0, quantity_i};
    end
    pack_new = coil_pack_q | (8'(value_i[0]) << coil_bit_pos_q);

    if (!command_i) begin
      // A header always abandons whatever frame was open.
      job_make        = 1'b1;
      frame_open_d    = 1'b0;
      open_coil_d     = 1'b0;
      elements_left_d = 11'd0;
      coil_pack_d     = 8'h00;
      coil_bit_pos_d  = 3'd0;
      job_byte_d[0]   = device_id_i;
      job_byte_d[1]   = function_code_i;
      job_byte_d[2]   = start_address_i[15:8];
      job_byte_d[3]   = start_address_i[7:0];
      job_init_d      = 1'b1;
      if (fc_short) begin
        job_byte_d[4] = word[15:8];
        job_byte_d[5] = word[7:0];
        job_kind_d[6] = mbrf_pkg::KIND_CRC_LO;
        job_kind_d[7] = mbrf_pkg::KIND_CRC_HI;
        job_last_d    = 3'd7;
      end else if (fc_long && (quantity_i != 11'd0)) begin
        job_byte_d[4]   = {5'd0, quantity_i[10:8]};
        job_byte_d[5]   = quantity_i[7:0];
        job_byte_d[6]   = count;
        job_last_d      = 3'd6;
        frame_open_d    = 1'b1;
        open_coil_d     = (function_code_i == mbrf_pkg::FC_WRITE_COILS);
        elements_left_d = quantity_i;
      end else begin
        job_init_d    = 1'b0;
        job_byte_d[0] = 8'h00;
        job_kind_d[0] = mbrf_pkg::KIND_BAD;
      end
    end else if (!frame_open_q || (elements_left_q == 11'd0)) begin
      job_make      = 1'b1;
      job_kind_d[0] = mbrf_pkg::KIND_BAD;
    end else begin
      elements_left_d = elements_left_q - 11'd1;
      if (open_coil_q) begin
        coil_pack_d    = pack_new;
        coil_bit_pos_d = coil_bit_pos_q + 3'd1;
        if ((coil_bit_pos_q == 3'd7) || (elements_left_q == 11'd1)) begin
          job_make       = 1'b1;
          job_byte_d[0]  = pack_new;
          coil_pack_d    = 8'h00;
          coil_bit_pos_d = 3'd0;
          if (elements_left_q == 11'd1) begin
            job_kind_d[1] = mbrf_pkg::KIND_CRC_LO;
            job_kind_d[2] = mbrf_pkg::KIND_CRC_HI;
            job_last_d    = 3'd2;
          end
        end
      end else begin
        job_make      = 1'b1;
        job_byte_d[0] = value_i[15:8];
        job_byte_d[1] = value_i[7:0];
        job_last_d    = 3'd1;
        if (elements_left_q == 11'd1) begin
          job_kind_d[2] = mbrf_pkg::KIND_CRC_LO;
          job_kind_d[3] = mbrf_pkg::KIND_CRC_HI;
          job_last_d    = 3'd3;
        end
      end
      if (elements_left_q == 11'd1) begin
        frame_open_d = 1'b0;
        open_coil_d  = 1'b0;
      end
    end
  end

  // Byte emission: the slot under the job index goes to the output register.
  always_comb begin
    logic [15:0] crc_base;
    crc_base  = (job_init_q && (job_idx_q == 3'd0)) ? mbrf_pkg::CRC_INIT : crc_q;
    crc_d     = crc_q;
    out_byte_d = 8'h00;
    out_end_d  = 1'b0;
    out_bad_d  = 1'b0;
    case (job_kind_q[job_idx_q])
      mbrf_pkg::KIND_DATA: begin
        out_byte_d = job_byte_q[job_idx_q];
        crc_d      = mbrf_pkg::crc_feed(crc_base, job_byte_q[job_idx_q]);
      end
      mbrf_pkg::KIND_CRC_LO: begin
        out_byte_d = crc_q[7:0];
      end
      mbrf_pkg::KIND_CRC_HI: begin
        out_byte_d = crc_q[15:8];
        out_end_d  = 1'b1;
        crc_d      = mbrf_pkg::CRC_INIT;
      end
      mbrf_pkg::KIND_BAD: begin
        out_bad_d = 1'b1;
      end
      default: begin
        out_bad_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_open_q    <= 1'b0;
      open_coil_q     <= 1'b0;
      elements_left_q <= 11'd0;
      coil_pack_q     <= 8'h00;
      coil_bit_pos_q  <= 3'd0;
      job_valid_q     <= 1'b0;
      job_idx_q       <= 3'd0;
      crc_q           <= mbrf_pkg::CRC_INIT;
      out_valid_q     <= 1'b0;
    end else begin
      if (in_xfer) begin
        frame_open_q    <= frame_open_d;
        open_coil_q     <= open_coil_d;
        elements_left_q <= elements_left_d;
        coil_pack_q     <= coil_pack_d;
        coil_bit_pos_q  <= coil_bit_pos_d;
      end
      if (advance) begin
        out_valid_q <= job_valid_q;
      end
      if (advance && job_valid_q) begin
        crc_q <= crc_d;
      end
      // A new job replaces the current one only as its last byte leaves.
      if (in_xfer && job_make) begin
        job_valid_q <= 1'b1;
        job_idx_q   <= 3'd0;
      end else if (advance && job_valid_q) begin
        if (job_idx_q == job_last_q) begin
          job_valid_q <= 1'b0;
        end else begin
          job_idx_q <= job_idx_q + 3'd1;
        end
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk_i) begin
    if (in_xfer && job_make) begin
      job_init_q <= job_init_d;
      job_last_q <= job_last_d;
      for (int s = 0; s < mbrf_pkg::SLOTS; s++) begin
        job_byte_q[s] <= job_byte_d[s];
        job_kind_q[s] <= job_kind_d[s];
      end
    end
    if (advance && job_valid_q) begin
      out_byte_q <= out_byte_d;
      out_end_q  <= out_end_d;
      out_bad_q  <= out_bad_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign frame_byte_o  = out_byte_q;
  assign frame_end_o   = out_end_q;
  assign bad_request_o = out_bad_q;

`ifndef NO_ASSERTIONS
  // A new item is only taken while the current job hands over its last byte.
  a_accept_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && job_valid_q) |-> (advance && (job_idx_q == job_last_q)))
    else $error("item accepted while job still has bytes to send");

  // An open frame always still expects at least one element.
  a_open_has_elements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_open_q |-> (elements_left_q != 11'd0))
    else $error("frame open with no elements left");

  // Partial coil bytes exist only inside an open coil frame.
  a_coil_pack_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (coil_bit_pos_q != 3'd0) |-> (frame_open_q && open_coil_q))
    else $error("coil bits pending outside a coil frame");

  // A rejected item never ends a frame.
  a_bad_not_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_bad_q) |-> !out_end_q)
    else $error("bad request marked as frame end");
`endif

endmodule
